### src/lds_pkg.sv
// ----------------------------------------------------------------------------
// Load sequencer package
// Types, opcode constants and the cycle cost table shared by the sequencer
// and its step logic.
// ----------------------------------------------------------------------------
package lds_pkg;

  localparam int AddrWidth  = 16;
  localparam int DataWidth  = 8;
  localparam int CycleWidth = 3;

  localparam logic [AddrWidth-1:0] VectorLoAddr = 16'hFFFC;
  localparam logic [AddrWidth-1:0] VectorHiAddr = 16'hFFFD;

  localparam logic [DataWidth-1:0] OP_IMM = 8'hA9;
  localparam logic [DataWidth-1:0] OP_ZP  = 8'hA5;
  localparam logic [DataWidth-1:0] OP_ZPX = 8'hB5;
  localparam logic [DataWidth-1:0] OP_ABS = 8'hAD;
  localparam logic [DataWidth-1:0] OP_ABX = 8'hBD;
  localparam logic [DataWidth-1:0] OP_ABY = 8'hB9;
  localparam logic [DataWidth-1:0] OP_INX = 8'hA1;
  localparam logic [DataWidth-1:0] OP_INY = 8'hB1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic CFG_INDEX_X = 1'b0;
  localparam logic CFG_INDEX_Y = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_VEC_LO = 4'd1,
    PH_VEC_HI = 4'd2,
    PH_OPCODE = 4'd3,
    PH_OPER1  = 4'd4,
    PH_OPER2  = 4'd5,
    PH_PTR_LO = 4'd6,
    PH_PTR_HI = 4'd7,
    PH_FINAL  = 4'd8
  } phase_t;

  typedef struct packed {
    logic [AddrWidth-1:0] pc;
    logic [DataWidth-1:0] acc;
    logic                 z;
    logic                 n;
    logic                 i;
    phase_t               phase;
    logic [DataWidth-1:0] opcode;
    logic [AddrWidth-1:0] work_addr;
    logic                 page_crossed;
  } lds_state_t;

  typedef struct packed {
    logic [AddrWidth-1:0]  read_address;
    logic [DataWidth-1:0]  accumulator;
    logic                  zero_flag;
    logic                  negative_flag;
    logic                  interrupt_disable;
    logic [AddrWidth-1:0]  program_counter;
    logic                  instruction_done;
    logic [CycleWidth-1:0] cycles_used;
    logic                  unknown_opcode;
  } lds_result_t;

  function automatic logic known_opcode(input logic [DataWidth-1:0] op);
    return (op == OP_IMM) || (op == OP_ZP) || (op == OP_ZPX) || (op == OP_ABS) ||
           (op == OP_ABX) || (op == OP_ABY) || (op == OP_INX) || (op == OP_INY);
  endfunction

  function automatic logic [CycleWidth-1:0] load_cost(input logic [DataWidth-1:0] op,
                                                      input logic page_crossed);
    logic [CycleWidth-1:0] cost;
    case (op)
      OP_IMM:         cost = 3'd2;
      OP_ZP:          cost = 3'd3;
      OP_ZPX:         cost = 3'd4;
      OP_ABS:         cost = 3'd4;
      OP_ABX, OP_ABY: cost = 3'd4 + {2'b00, page_crossed};
      OP_INX:         cost = 3'd6;
      default:        cost = 3'd5 + {2'b00, page_crossed};
    endcase
    return cost;
  endfunction

endpackage

### src/lda_addressing_sequencer.sv
// ----------------------------------------------------------------------------
// Load accumulator addressing sequencer
// Bus-cycle sequencer of an 8-bit core that runs only load accumulator.
//
// Each input beat is a start command or the byte memory returned for the
// address requested by the previous result. Each input beat gives exactly one
// result beat: the next read address, the architectural registers, and the
// completion, cost and unknown-opcode flags of an instruction ending there.
// The user must write the index registers through the cfg port only while the
// block idles; the block does not enforce it. The result is registered when
// its beat is accepted. One beat is taken every cycle unless stalled; the
// state update and the result are computed combinationally between the state
// and output registers. A stall on the result side holds the output register
// and stalls the input side in the same cycle unless the result is taken.
// Reset clears the state, sets the interrupt disable flag and empties the
// output register; data beats before the first start answer address zero.
// ----------------------------------------------------------------------------
module lda_addressing_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_read_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_read_address,
  output logic [7:0]  out_accumulator,
  output logic        out_zero_flag,
  output logic        out_negative_flag,
  output logic        out_interrupt_disable,
  output logic [15:0] out_program_counter,
  output logic        out_instruction_done,
  output logic [2:0]  out_cycles_used,
  output logic        out_unknown_opcode
);
  import lds_pkg::*;

  lds_state_t  state_r;
  lds_state_t  state_nxt;
  lds_result_t result_r;
  lds_result_t result_nxt;
  logic        out_valid_r;
  logic [7:0]  index_x_r;
  logic [7:0]  index_y_r;
  logic        in_accept;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  lds_step u_step (
    .state     (state_r),
    .cmd       (in_cmd),
    .read_data (in_read_data),
    .index_x   (index_x_r),
    .index_y   (index_y_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_x_r <= '0;
      index_y_r <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_INDEX_X: index_x_r <= cfg_data;
        CFG_INDEX_Y: index_y_r <= cfg_data;
        default:     index_x_r <= index_x_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '{pc: '0, acc: '0, z: 1'b0, n: 1'b0, i: 1'b1, phase: PH_IDLE,
                       opcode: '0, work_addr: '0, page_crossed: 1'b0};
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r <= state_nxt;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_read_address      = result_r.read_address;
  assign out_accumulator       = result_r.accumulator;
  assign out_zero_flag         = result_r.zero_flag;
  assign out_negative_flag     = result_r.negative_flag;
  assign out_interrupt_disable = result_r.interrupt_disable;
  assign out_program_counter   = result_r.program_counter;
  assign out_instruction_done  = result_r.instruction_done;
  assign out_cycles_used       = result_r.cycles_used;
  assign out_unknown_opcode    = result_r.unknown_opcode;

  a_reset_sets_i: assert property (@(posedge clk) !rst_n |=> state_r.i)
    else $error("interrupt disable not set after reset");

  a_done_has_cost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_instruction_done |-> out_cycles_used != 3'd0)
    else $error("completed instruction reported without a cost");

  a_unknown_cost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_unknown_opcode |-> out_instruction_done && out_cycles_used == 3'd1)
    else $error("unknown opcode not reported as a one-cycle instruction");

  a_idle_cost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_instruction_done |-> out_cycles_used == 3'd0 && !out_unknown_opcode)
    else $error("cost reported without a completed instruction");

  a_idle_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && state_r.phase == PH_IDLE |-> out_read_address == 16'h0000)
    else $error("read address requested before the first start");

endmodule

### src/lds_step.sv
// ----------------------------------------------------------------------------
// Load sequencer step logic
// Combinational next state and result for one bus beat.
// ----------------------------------------------------------------------------
module lds_step (
  input  lds_pkg::lds_state_t       state,
  input  logic                      cmd,
  input  logic [7:0]                read_data,
  input  logic [7:0]                index_x,
  input  logic [7:0]                index_y,
  output lds_pkg::lds_state_t       state_nxt,
  output lds_pkg::lds_result_t      result
);
  import lds_pkg::*;

  logic [AddrWidth-1:0] base_oper;
  logic [AddrWidth-1:0] base_ptr;
  logic [DataWidth-1:0] abs_idx;
  logic [AddrWidth-1:0] abs_sum;
  logic [DataWidth:0]   abs_low;
  logic [AddrWidth-1:0] iny_sum;
  logic [DataWidth:0]   iny_low;
  logic [DataWidth-1:0] zp_sum;
  logic                 do_load;

  assign base_oper = {read_data, state.work_addr[7:0]};
  assign base_ptr  = {read_data, state.work_addr[15:8]};
  assign abs_idx   = (state.opcode == OP_ABX) ? index_x : index_y;
  assign abs_sum   = base_oper + {8'h00, abs_idx};
  assign abs_low   = {1'b0, base_oper[7:0]} + {1'b0, abs_idx};
  assign iny_sum   = base_ptr + {8'h00, index_y};
  assign iny_low   = {1'b0, base_ptr[7:0]} + {1'b0, index_y};
  assign zp_sum    = read_data + index_x;

  assign do_load = (cmd == CMD_DATA) &&
                   ((state.phase == PH_FINAL) ||
                    ((state.phase == PH_OPER1) && (state.opcode == OP_IMM)));

  always_comb begin
    state_nxt = state;
    if (cmd == CMD_START) begin
      state_nxt.i            = 1'b1;
      state_nxt.page_crossed = 1'b0;
      state_nxt.phase        = PH_VEC_LO;
    end else begin
      if (do_load) begin
        state_nxt.acc = read_data;
        state_nxt.z   = (read_data == 8'h00);
        state_nxt.n   = read_data[7];
      end
      case (state.phase)
        PH_VEC_LO: begin
          state_nxt.work_addr = {8'h00, read_data};
          state_nxt.phase     = PH_VEC_HI;
        end
        PH_VEC_HI: begin
          state_nxt.pc    = {read_data, state.work_addr[7:0]};
          state_nxt.phase = PH_OPCODE;
        end
        PH_OPCODE: begin
          state_nxt.pc           = state.pc + 16'd1;
          state_nxt.page_crossed = 1'b0;
          if (known_opcode(read_data)) begin
            state_nxt.opcode = read_data;
            state_nxt.phase  = PH_OPER1;
          end
        end
        PH_OPER1: begin
          state_nxt.pc = state.pc + 16'd1;
          case (state.opcode)
            OP_IMM: begin
              state_nxt.phase = PH_OPCODE;
            end
            OP_ZP: begin
              state_nxt.work_addr = {8'h00, read_data};
              state_nxt.phase     = PH_FINAL;
            end
            OP_ZPX: begin
              state_nxt.work_addr = {8'h00, zp_sum};
              state_nxt.phase     = PH_FINAL;
            end
            OP_INX: begin
              state_nxt.work_addr = {8'h00, zp_sum};
              state_nxt.phase     = PH_PTR_LO;
            end
            OP_INY: begin
              state_nxt.work_addr = {8'h00, read_data};
              state_nxt.phase     = PH_PTR_LO;
            end
            default: begin
              state_nxt.work_addr = {8'h00, read_data};
              state_nxt.phase     = PH_OPER2;
            end
          endcase
        end
        PH_OPER2: begin
          state_nxt.pc    = state.pc + 16'd1;
          state_nxt.phase = PH_FINAL;
          if ((state.opcode == OP_ABX) || (state.opcode == OP_ABY)) begin
            state_nxt.work_addr    = abs_sum;
            state_nxt.page_crossed = abs_low[8];
          end else begin
            state_nxt.work_addr = base_oper;
          end
        end
        PH_PTR_LO: begin
          state_nxt.work_addr = {read_data, state.work_addr[7:0] + 8'd1};
          state_nxt.phase     = PH_PTR_HI;
        end
        PH_PTR_HI: begin
          state_nxt.phase = PH_FINAL;
          if (state.opcode == OP_INY) begin
            state_nxt.work_addr    = iny_sum;
            state_nxt.page_crossed = iny_low[8];
          end else begin
            state_nxt.work_addr = base_ptr;
          end
        end
        PH_FINAL: begin
          state_nxt.phase = PH_OPCODE;
        end
        default: begin
          state_nxt.phase = state.phase;
        end
      endcase
    end
  end

  always_comb begin
    result                   = '0;
    result.accumulator       = state_nxt.acc;
    result.zero_flag         = state_nxt.z;
    result.negative_flag     = state_nxt.n;
    result.interrupt_disable = state_nxt.i;
    result.program_counter   = state_nxt.pc;
    case (state_nxt.phase)
      PH_VEC_LO: result.read_address = VectorLoAddr;
      PH_VEC_HI: result.read_address = VectorHiAddr;
      PH_OPCODE, PH_OPER1, PH_OPER2: result.read_address = state_nxt.pc;
      PH_PTR_LO, PH_PTR_HI: result.read_address = {8'h00, state_nxt.work_addr[7:0]};
      PH_FINAL:  result.read_address = state_nxt.work_addr;
      default:   result.read_address = '0;
    endcase
    if (do_load) begin
      result.instruction_done = 1'b1;
      result.cycles_used      = load_cost(state.opcode, state.page_crossed);
    end else if ((cmd == CMD_DATA) && (state.phase == PH_OPCODE) &&
                 !known_opcode(read_data)) begin
      result.instruction_done = 1'b1;
      result.cycles_used      = 3'd1;
      result.unknown_opcode   = 1'b1;
    end
  end

endmodule
